[rtl/wakeup_latency_tracker_top_defines.svh]
// Assertion helpers shared by the tracker RTL.
`ifndef WAKEUP_LATENCY_TRACKER_TOP_DEFINES_SVH
`define WAKEUP_LATENCY_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication under reset.
`define WLT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define WLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never hold out of reset.
`define WLT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[rtl/wlt_pkg.sv]
package wlt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam int TASK_W  = 22;
    localparam int TIME_W  = 64;
    localparam int CPU_W   = 8;
    localparam int DELAY_W = 55;
    localparam int MIN_W   = 32;

    localparam logic [MIN_W-1:0] MIN_DELAY_RESET = 32'd1000000;

    localparam int NS_PER_US = 1000;
    localparam int REM_W     = $clog2(NS_PER_US);

    // Divide by NS_PER_US one digit at a time: each digit is a reciprocal
    // multiply step followed by a subtract step.
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_DIGITS  = TIME_W / DIV_DIGIT_W;
    localparam int DIV_STEPS   = 2 * DIV_DIGITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int DIV_NUM_W   = REM_W + DIV_DIGIT_W;
    // ceil(2^RECIP_SHIFT / NS_PER_US), exact for every DIV_NUM_W-bit numerator
    localparam int RECIP_SHIFT = DIV_NUM_W + REM_W;
    localparam int RECIP_W     = 27;
    localparam int DIV_PROD_W  = DIV_NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_NS_PER_US = 27'd68719477;

    localparam int S_FIELDS_W = TASK_W + TIME_W + CPU_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = TIME_W + TASK_W + CPU_W + DELAY_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic ACT_WAKEUP = 1'b0;
    localparam logic ACT_SWITCH = 1'b1;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic scan_run;
        logic commit;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pass;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

[rtl/wlt_ctrl.sv]
module wlt_ctrl
    import wlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = status.pass ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/wlt_datapath.sv]
`include "wakeup_latency_tracker_top_defines.svh"

module wlt_datapath
    import wlt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 cfg_wr_en,
    input  logic [MIN_W-1:0]     cfg_wr_data,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Configuration
    logic [MIN_W-1:0] min_delay_reg;

    // Captured event
    logic              action_reg;
    logic [TASK_W-1:0] task_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CPU_W-1:0]  cpu_reg;

    // Table
    entry_t                 mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [TABLE_SLOTS-1:0] valid_next;

    // Scan
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [SLOT_W-1:0] scan_idx;
    logic              issue;
    logic              pipe_vld_reg;
    logic              rd_slot_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    entry_t            rd_entry_reg;
    logic              match;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [TIME_W-1:0] start_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;

    // Update
    logic [TIME_W-1:0] delta;
    logic              delta_ge;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;

    // Divider
    logic [TIME_W-1:0]      quo_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   div_phase;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_PROD_W-1:0]  div_prod;
    logic [DIV_DIGIT_W-1:0] digit_reg;
    logic [REM_W-1:0]       rem_next;

    // Output
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg <= MIN_DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_delay_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= s_tuser[0];
            task_reg   <= s_tdata[TASK_W-1:0];
            time_reg   <= s_tdata[TASK_W+TIME_W-1:TASK_W];
            cpu_reg    <= s_tdata[S_FIELDS_W-1:TASK_W+TIME_W];
        end
    end

    // Scan: issue one read per cycle, compare the tag in the cycle after.
    assign scan_idx = scan_cnt_reg[SLOT_W-1:0];
    assign issue    = cmd.scan_run && (scan_cnt_reg < CNT_W'(TABLE_SLOTS));
    assign match    = pipe_vld_reg && rd_slot_vld_reg && (rd_entry_reg.task_id == task_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            scan_cnt_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= issue;
            if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (!valid_reg[scan_idx] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (match)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_entry_reg    <= mem[scan_idx];
            rd_idx_reg      <= scan_idx;
            rd_slot_vld_reg <= valid_reg[scan_idx];
            if (!valid_reg[scan_idx] && !free_found_reg)
            begin
                free_idx_reg <= scan_idx;
            end
        end
        if (match && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            start_reg   <= rd_entry_reg.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= '{task_id: task_reg, start: time_reg};
        end
    end

    assign status.scan_done = (scan_cnt_reg == CNT_W'(TABLE_SLOTS)) && !pipe_vld_reg;

    // Update
    assign delta    = time_reg - start_reg;
    assign delta_ge = delta >= {{(TIME_W-MIN_W){1'b0}}, min_delay_reg};
    assign wr_en    = cmd.commit && (action_reg == ACT_WAKEUP) && (hit_reg || free_found_reg);
    assign wr_idx   = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        else if (cmd.commit && (action_reg == ACT_SWITCH) && hit_reg)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign status.pass = (action_reg == ACT_SWITCH) && hit_reg && delta_ge;

    // Divide by 1000 one 16-bit digit at a time, high digit first. Even steps
    // estimate the digit by a reciprocal multiply; odd steps subtract it back
    // out of the partial remainder and shift it into the quotient.
    assign div_phase = div_cnt_reg[0];
    assign div_num   = {rem_reg, quo_reg[TIME_W-1 -: DIV_DIGIT_W]};
    assign div_prod  = DIV_PROD_W'(div_num) * DIV_PROD_W'(RECIP_NS_PER_US);
    assign rem_next  = REM_W'(div_num - DIV_NUM_W'(digit_reg) * DIV_NUM_W'(NS_PER_US));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_phase)
            begin
                rem_reg <= rem_next;
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            quo_reg <= delta;
        end
        else if (cmd.div_step)
        begin
            if (!div_phase)
            begin
                digit_reg <= div_prod[RECIP_SHIFT +: DIV_DIGIT_W];
            end
            else
            begin
                quo_reg <= {quo_reg[TIME_W-DIV_DIGIT_W-1:0], digit_reg};
            end
        end
    end

    assign status.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    // Output register
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, quo_reg[DELAY_W-1:0], cpu_reg, task_reg, time_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `WLT_ASSERT_IMPLIES(a_hit_slot_live, clk, rst_n, cmd.commit && hit_reg, valid_reg[hit_idx_reg], "matched slot is not live at update")
    `WLT_ASSERT_NEXT(a_switch_frees, clk, rst_n, cmd.commit && (action_reg == ACT_SWITCH) && hit_reg, !valid_reg[$past(hit_idx_reg)], "switch hit did not free its slot")
    `WLT_ASSERT_NEVER(a_rem_range, clk, rst_n, rem_reg >= REM_W'(NS_PER_US), "divider remainder out of range")
    `WLT_ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.out_load, !m_tvalid_reg || m_tready, "record loaded over an untaken record")

endmodule

[rtl/wakeup_latency_tracker_top.sv]
// Wakeup latency tracker. Each input transaction is a wakeup (s_tuser = 0) or a
// switch-in (s_tuser = 1) of a task, stamped with a 64-bit ns time and a cpu id.
// A wakeup stores the task's start time in a fully associative table of
// TABLE_SLOTS entries (refreshing the entry if the task is already there, taking
// the lowest free slot otherwise, dropping the wakeup if the table is full).
// A switch looks the task up, frees its entry and, when the elapsed time
// (wrapping mod 2^64) reaches min_delay_ns, emits one record with the switch
// time, task, cpu and the delay in whole microseconds. One transaction is in
// flight at a time: the lookup sweeps the table memory one slot a cycle, and
// the next transaction is taken only once the current one is done. A
// transaction that yields a record then divides the delay by 1000 (four 16-bit
// digits, each a reciprocal multiply then a subtract) and loads the output
// register, after any wait for the previous record to leave the output
// register. The output register decouples the two sides: a new transaction is
// accepted while a record still waits for m_tready. min_delay_ns must be
// written through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block itself does not enforce this. It resets to 1000000. The table comes
// out of reset empty with no clearing pass.
module wakeup_latency_tracker_top
    import wlt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // task_id[21:0], time_ns[85:22], cpu_id[93:86], zero fill[95:94]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]: 0 wakeup, 1 switch-in
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // event_time_ns[63:0], task_tag[85:64], cpu_tag[93:86], delay_us[148:94],
    // zero fill[151:149]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [MIN_W-1:0]     cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    // Sequence each transaction: accept, scan, update and, when it yields a record, divide and emit.
    wlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table memory, valid bits, divider and output register.
    wlt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
